// File: design/crcf_pkg.sv
// crcf_pkg: shared types, constants and the byte-wide crc update for the packet framer
// used by every module of crc_packet_framer; no dependencies
`timescale 1ns / 1ps

package crcf_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0]  EndMark = 8'h7E;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_SYNC_FIRST        = 3'd0,
    CFG_SYNC_SECOND       = 3'd1,
    CFG_VERSION_BYTE      = 3'd2,
    CFG_PACKET_KIND       = 3'd3,
    CFG_PAYLOAD_LENGTH    = 3'd4,
    CFG_END_MARKER_ENABLE = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  version_byte;
    logic [7:0]  packet_kind;
    logic [15:0] payload_length;
    logic        end_marker_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] sequence_number;
  } item_t;

  // request held in the input stage and its valid flag
  typedef struct packed {
    logic  valid;
    item_t item;
  } item_slot_t;

  typedef enum logic [3:0] {
    PH_START,
    PH_SYNC_FIRST,
    PH_SYNC_SECOND,
    PH_VERSION,
    PH_KIND,
    PH_SEQ_LO,
    PH_SEQ_HI,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CRC_LO,
    PH_CRC_HI,
    PH_END_MARK
  } phase_t;

  // crc-16/ccitt-false, msb first, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: design/crcf_cfg_regs.sv
// crcf_cfg_regs: configuration register file written through a plain write port
// depends on crcf_pkg
`timescale 1ns / 1ps

module crcf_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_enable,
  input  logic [crcf_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [crcf_pkg::CfgDataWidth-1:0]    cfg_data,
  output crcf_pkg::cfg_t                       cfg
);
  import crcf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first        <= 8'hAA;
      cfg.sync_second       <= 8'h55;
      cfg.version_byte      <= 8'h01;
      cfg.packet_kind       <= 8'h01;
      cfg.payload_length    <= 16'd57;
      cfg.end_marker_enable <= 1'b0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST:        cfg.sync_first        <= cfg_data[7:0];
        CFG_SYNC_SECOND:       cfg.sync_second       <= cfg_data[7:0];
        CFG_VERSION_BYTE:      cfg.version_byte      <= cfg_data[7:0];
        CFG_PACKET_KIND:       cfg.packet_kind       <= cfg_data[7:0];
        CFG_PAYLOAD_LENGTH:    cfg.payload_length    <= cfg_data[15:0];
        CFG_END_MARKER_ENABLE: cfg.end_marker_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/crcf_in_stage.sv
// crcf_in_stage: input register holding one payload request until the emitter finishes it
// depends on crcf_pkg
`timescale 1ns / 1ps

module crcf_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           payload_byte,
  input  logic [15:0]          sequence_number,
  input  logic                 done,
  output crcf_pkg::item_slot_t slot
);
  import crcf_pkg::*;

  logic accept;

  assign in_stall = slot.valid && !done;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (accept) begin
      slot.valid <= 1'b1;
    end else if (done) begin
      slot.valid <= 1'b0;
    end
    if (accept) begin
      slot.item.payload_byte    <= payload_byte;
      slot.item.sequence_number <= sequence_number;
    end
  end

endmodule

// File: design/crcf_emitter.sv
// crcf_emitter: per request, walks header (if first), payload and trailer (if last) bytes,
// one per unstalled cycle; keeps byte count and crc, drives the output register; uses crcf_pkg
`timescale 1ns / 1ps

module crcf_emitter (
  input  logic                 clk,
  input  logic                 rst,
  input  crcf_pkg::cfg_t       cfg,
  input  crcf_pkg::item_slot_t slot,
  output logic                 done,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 run_end,
  output logic                 packet_end
);
  import crcf_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  phase_t      cur;
  logic [15:0] byte_count;
  logic [15:0] byte_count_next;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [15:0] crc_base;
  logic [15:0] count_inc;
  logic        closing;
  logic        emit;
  logic [7:0]  byte_sel;
  logic        feed;
  logic        run_end_sel;
  logic        packet_end_sel;

  assign emit      = slot.valid && (!out_valid || !out_stall);
  assign count_inc = byte_count + 16'd1;
  assign closing   = count_inc >= cfg.payload_length;
  assign cur       = (phase != PH_START) ? phase :
                     (byte_count == 16'd0) ? PH_SYNC_FIRST : PH_PAYLOAD;
  assign crc_base  = (cur == PH_SYNC_FIRST) ? CrcInit : crc;
  assign done      = emit && run_end_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      byte_count <= 16'd0;
      crc        <= CrcInit;
    end else begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      crc        <= crc_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    crc_next        = crc;
    byte_sel        = slot.item.payload_byte;
    feed            = 1'b1;
    run_end_sel     = 1'b0;
    packet_end_sel  = 1'b0;
    unique case (cur)
      PH_SYNC_FIRST: begin
        byte_sel   = cfg.sync_first;
        phase_next = PH_SYNC_SECOND;
      end
      PH_SYNC_SECOND: begin
        byte_sel   = cfg.sync_second;
        phase_next = PH_VERSION;
      end
      PH_VERSION: begin
        byte_sel   = cfg.version_byte;
        phase_next = PH_KIND;
      end
      PH_KIND: begin
        byte_sel   = cfg.packet_kind;
        phase_next = PH_SEQ_LO;
      end
      PH_SEQ_LO: begin
        byte_sel   = slot.item.sequence_number[7:0];
        phase_next = PH_SEQ_HI;
      end
      PH_SEQ_HI: begin
        byte_sel   = slot.item.sequence_number[15:8];
        phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        byte_sel   = cfg.payload_length[7:0];
        phase_next = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        byte_sel   = cfg.payload_length[15:8];
        phase_next = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        byte_sel        = slot.item.payload_byte;
        byte_count_next = closing ? 16'd0 : count_inc;
        phase_next      = closing ? PH_CRC_LO : PH_START;
        run_end_sel     = !closing;
      end
      PH_CRC_LO: begin
        byte_sel   = crc[7:0];
        feed       = 1'b0;
        phase_next = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        byte_sel       = crc[15:8];
        feed           = 1'b0;
        phase_next     = cfg.end_marker_enable ? PH_END_MARK : PH_START;
        run_end_sel    = !cfg.end_marker_enable;
        packet_end_sel = !cfg.end_marker_enable;
      end
      PH_END_MARK: begin
        byte_sel       = EndMark;
        feed           = 1'b0;
        phase_next     = PH_START;
        run_end_sel    = 1'b1;
        packet_end_sel = 1'b1;
      end
      default: begin
        phase_next = PH_START;
      end
    endcase
    if (feed) begin
      crc_next = crc_byte(crc_base, byte_sel);
    end else if (packet_end_sel) begin
      crc_next = CrcInit;
    end
    if (!emit) begin
      phase_next      = phase;
      byte_count_next = byte_count;
      crc_next        = crc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= byte_sel;
      run_end    <= run_end_sel;
      packet_end <= packet_end_sel;
    end
  end

endmodule

// File: design/crc_packet_framer.sv
// crc_packet_framer: frames payload bytes into packets with header and crc-16 trailer
// each request is registered in the input stage, then each of its bytes in the output register
// output: one byte per cycle unless out_stall holds the output register; a middle
// payload byte gives 1 output byte, a first byte 9, a last byte 3 or 4, a byte that both
// opens and closes a packet 11 or 12
// reset: synchronous; clears the packet byte count, crc to 0xffff and config to defaults
`timescale 1ns / 1ps

module crc_packet_framer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_enable,
  input  logic [crcf_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [crcf_pkg::CfgDataWidth-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         payload_byte,
  input  logic [15:0]                        sequence_number,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_byte,
  output logic                               run_end,
  output logic                               packet_end
);
  import crcf_pkg::*;

  cfg_t       cfg;
  item_slot_t slot;
  logic       done;

  crcf_cfg_regs u_cfg_regs (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cfg              (cfg)
  );

  crcf_in_stage u_in_stage (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .payload_byte    (payload_byte),
    .sequence_number (sequence_number),
    .done            (done),
    .slot            (slot)
  );

  crcf_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .slot       (slot),
    .done       (done),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .packet_end (packet_end)
  );

endmodule
